/* sv/radix_prefixed_integer_parser_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef RADIX_PREFIXED_INTEGER_PARSER_DEFINES_SVH
`define RADIX_PREFIXED_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rpip_pkg.sv */
// Types and character constants for the radix-prefixed integer parser.
package rpip_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic               is_string;
    } t_out;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_SIGN   = 5'b00010,
        PH_FIRST  = 5'b00100,
        PH_ZERO   = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [4:0] RADIX_2  = 5'd2;
    localparam logic [4:0] RADIX_8  = 5'd8;
    localparam logic [4:0] RADIX_10 = 5'd10;
    localparam logic [4:0] RADIX_16 = 5'd16;
    localparam logic [4:0] DIGIT_NONE = 5'd31;

endpackage

/* sv/radix_prefixed_integer_parser.sv */
// Radix-prefixed integer parser: one character per transaction, one number out.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------
//  input    | i_in_valid   | o_in_stall   | i_in_data  (ch, start_req)
//  output   | o_out_valid  | i_out_stall  | o_out_data (value, is_string)
//
// One character per cycle while the input is not stalled; a result appears in the output
// register in the cycle after the character that closes the value.
// Parse state and the output register update in the same cycle as the
// character is taken; the digit step is a shift-and-add by the radix.
// Reset (synchronous, active low) returns to idle with an empty output.
// Input stalls only while a result waits and the output is stalled.
`include "radix_prefixed_integer_parser_defines.svh"

module radix_prefixed_integer_parser
    import rpip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_phase      r_phase, n_phase;
    logic [4:0]  r_radix, n_radix;
    logic [31:0] r_acc, n_acc;
    logic        r_neg, n_neg;
    logic        r_bad, n_bad;
    logic        r_out_valid;
    t_out        r_out, n_res;
    logic        w_fire;
    logic        w_in_acc;
    logic        w_sep;
    logic [4:0]  w_digit;
    logic [31:0] w_scaled;
    logic [31:0] w_signed;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_sep = (i_in_data.ch == CH_SPACE) || (i_in_data.ch == CH_NUL) ||
                   (i_in_data.ch == CH_TAB)   || (i_in_data.ch == CH_COMMA);

    always_comb begin
        w_digit = DIGIT_NONE;
        if (i_in_data.ch >= CH_0 && i_in_data.ch <= CH_9) begin
            w_digit = 5'(i_in_data.ch - CH_0);
        end else if (i_in_data.ch >= CH_LA && i_in_data.ch <= CH_LF) begin
            w_digit = 5'(i_in_data.ch - CH_LA + 8'd10);
        end else if (i_in_data.ch >= CH_UA && i_in_data.ch <= CH_UF) begin
            w_digit = 5'(i_in_data.ch - CH_UA + 8'd10);
        end
    end

    // acc * radix as shifts; radix is always one of the four values
    always_comb begin
        case (r_radix)
            RADIX_2:  w_scaled = {r_acc[30:0], 1'b0};
            RADIX_8:  w_scaled = {r_acc[28:0], 3'b000};
            RADIX_16: w_scaled = {r_acc[27:0], 4'b0000};
            default:  w_scaled = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0};
        endcase
    end

    assign w_signed = r_neg ? (32'd0 - r_acc) : r_acc;

    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_bad   = r_bad;
        w_fire  = 1'b0;
        n_res.value     = w_signed;
        n_res.is_string = 1'b0;
        if (i_in_data.start_req) begin
            n_radix = RADIX_10;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_bad   = 1'b0;
            if (i_in_data.ch == CH_EQ) begin
                n_phase = PH_SIGN;
            end else begin
                n_phase = PH_IDLE;
                w_fire  = 1'b1;
                n_res.value = 32'sd1;
            end
        end else begin
            unique case (r_phase) inside
                PH_IDLE: begin
                end
                PH_SIGN, PH_FIRST: begin
                    if (r_phase == PH_SIGN && i_in_data.ch == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_FIRST;
                    end else if (w_sep) begin
                        w_fire  = 1'b1;
                        n_phase = PH_IDLE;
                        n_res.value     = '0;
                        n_res.is_string = 1'b1;
                    end else if (i_in_data.ch == CH_0) begin
                        n_acc   = '0;
                        n_phase = PH_ZERO;
                    end else if (i_in_data.ch >= CH_1 && i_in_data.ch <= CH_9) begin
                        n_acc   = {27'd0, w_digit};
                        n_radix = RADIX_10;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_bad   = 1'b1;
                        n_phase = PH_DIGITS;
                    end
                end
                PH_ZERO: begin
                    if (w_sep) begin
                        w_fire  = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_DIGITS;
                        if (i_in_data.ch == CH_X) begin
                            n_radix = RADIX_16;
                        end else if (i_in_data.ch == CH_B) begin
                            n_radix = RADIX_2;
                        end else if (i_in_data.ch >= CH_0 && i_in_data.ch <= CH_7) begin
                            n_acc   = {27'd0, w_digit};
                            n_radix = RADIX_8;
                        end else begin
                            n_bad = 1'b1;
                        end
                    end
                end
                PH_DIGITS: begin
                    if (w_sep) begin
                        w_fire  = 1'b1;
                        n_phase = PH_IDLE;
                        if (r_bad) begin
                            n_res.value     = '0;
                            n_res.is_string = 1'b1;
                        end
                    end else if (w_digit >= r_radix) begin
                        n_bad = 1'b1;
                    end else begin
                        n_acc = w_scaled + {27'd0, w_digit};
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_radix     <= RADIX_10;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_phase <= n_phase;
                r_radix <= n_radix;
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_bad   <= n_bad;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= w_in_acc & w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_fire) begin
            r_out <= n_res;
        end
    end

    `RPIP_ASSERT_NOW(a_string_zero, r_out_valid && r_out.is_string, r_out.value == 32'sd0,
        "string result carries a nonzero value")
    `RPIP_ASSERT_NEXT(a_plain_start, w_in_acc && i_in_data.start_req && i_in_data.ch != CH_EQ,
        r_out_valid && r_out.value == 32'sd1 && !r_out.is_string && r_phase == PH_IDLE,
        "start without '=' did not give number one")
    `RPIP_ASSERT_NEXT(a_fire_idle, w_in_acc && w_fire, r_out_valid && r_phase == PH_IDLE,
        "result issued but parser not back to idle")
    `RPIP_ASSERT_NEXT(a_idle_ignore, w_in_acc && !i_in_data.start_req && r_phase == PH_IDLE,
        r_phase == PH_IDLE && r_acc == $past(r_acc),
        "idle parser reacted to a character without start")

endmodule
